// ===== sv/tmr_pkg.sv =====
// ----------------------------------------------------------------------------
// tmr_pkg
// Shared types and constants for the prescaled auto-reload timer: request
// codes, register map, control bit positions and the request/response structs.
// ----------------------------------------------------------------------------
package tmr_pkg;

   // Width of the bus data and of the prescaler
   localparam int DATA_WIDTH     = 16;
   localparam int PRESCALE_WIDTH = 16;

   // Control register bit positions
   localparam int CTRL_EN_BIT  = 0;
   localparam int CTRL_OPM_BIT = 3;
   localparam int CTRL_DIR_BIT = 4;

   // Request kinds; code 3 is unused and does nothing
   typedef enum logic [1:0] {
      MODE_TICK  = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_READ  = 2'd2
   } mode_type;

   // Register map; indexes 6 and 7 are unused
   typedef enum logic [2:0] {
      REG_CONTROL   = 3'd0,
      REG_PRESCALER = 3'd1,
      REG_RELOAD    = 3'd2,
      REG_EVENT     = 3'd3,
      REG_STATUS    = 3'd4,
      REG_COUNT     = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [1:0]            mode;
      logic [2:0]            reg_index;
      logic [DATA_WIDTH-1:0] write_data;
   } req_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] read_data;
      logic                  update_flag;
      logic                  running;
   } rsp_type;

endpackage

// ===== sv/tmr_core.sv =====
// ----------------------------------------------------------------------------
// tmr_core
// Timer register file and single-pass next-state logic. One request is
// applied to the state per cycle in which step is high; the response fields
// are available combinationally for the output register.
// ----------------------------------------------------------------------------
module tmr_core
   import tmr_pkg::*;
#(
   parameter int COUNTER_WIDTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type item,
   output rsp_type result
);

   // Timer state
   logic                      enable_ff, enable_in;
   logic                      one_pulse_ff, one_pulse_in;
   logic                      down_ff, down_in;
   logic [PRESCALE_WIDTH-1:0] prescale_written_ff, prescale_written_in;
   logic [PRESCALE_WIDTH-1:0] prescale_active_ff, prescale_active_in;
   logic [PRESCALE_WIDTH-1:0] prescale_count_ff, prescale_count_in;
   logic [COUNTER_WIDTH-1:0]  reload_ff, reload_in;
   logic [COUNTER_WIDTH-1:0]  count_ff, count_in;
   logic                      pending_ff, pending_in;

   // Bus data fitted to the counter width, counter values fitted to the bus
   logic [31:0]              data_wide;
   logic [COUNTER_WIDTH-1:0] data_cnt;
   logic [31:0]              count_wide;
   logic [31:0]              reload_wide;
   logic                     wrap;
   logic [DATA_WIDTH-1:0]    read_data;

   assign data_wide   = {16'd0, item.write_data};
   assign data_cnt    = data_wide[COUNTER_WIDTH-1:0];
   assign count_wide  = 32'(count_ff);
   assign reload_wide = 32'(reload_ff);

   // Next state for one request
   always_comb begin
      enable_in           = enable_ff;
      one_pulse_in        = one_pulse_ff;
      down_in             = down_ff;
      prescale_written_in = prescale_written_ff;
      prescale_active_in  = prescale_active_ff;
      prescale_count_in   = prescale_count_ff;
      reload_in           = reload_ff;
      count_in            = count_ff;
      pending_in          = pending_ff;
      wrap                = 1'b0;

      unique case (item.mode)
         MODE_TICK: begin
            if (enable_ff) begin
               if (prescale_count_ff >= prescale_active_ff) begin
                  prescale_count_in = '0;
                  if (down_ff) begin
                     if (count_ff == '0) begin
                        count_in = reload_ff;
                        wrap     = 1'b1;
                     end else begin
                        count_in = count_ff - 1'b1;
                     end
                  end else begin
                     if (count_ff == reload_ff) begin
                        count_in = '0;
                        wrap     = 1'b1;
                     end else begin
                        count_in = count_ff + 1'b1;
                     end
                  end
               end else begin
                  prescale_count_in = prescale_count_ff + 1'b1;
               end
            end
         end
         MODE_WRITE: begin
            unique case (item.reg_index)
               REG_CONTROL: begin
                  enable_in    = item.write_data[CTRL_EN_BIT];
                  one_pulse_in = item.write_data[CTRL_OPM_BIT];
                  down_in      = item.write_data[CTRL_DIR_BIT];
               end
               REG_PRESCALER: prescale_written_in = item.write_data;
               REG_RELOAD:    reload_in = data_cnt;
               REG_EVENT: begin
                  // forced update: restart counter and prescaler
                  if (item.write_data[0]) begin
                     count_in           = down_ff ? reload_ff : '0;
                     prescale_count_in  = '0;
                     pending_in         = 1'b1;
                     prescale_active_in = prescale_written_ff;
                  end
               end
               REG_STATUS: begin
                  if (!item.write_data[0]) begin
                     pending_in = 1'b0;
                  end
               end
               REG_COUNT: count_in = data_cnt;
               default: ;
            endcase
         end
         default: ;
      endcase

      // Counter wrap: update event and one-pulse stop
      if (wrap) begin
         pending_in         = 1'b1;
         prescale_active_in = prescale_written_ff;
         if (one_pulse_ff) begin
            enable_in = 1'b0;
         end
      end
   end

   // Register readback
   always_comb begin
      read_data = '0;
      if (item.mode == MODE_READ) begin
         unique case (item.reg_index)
            REG_CONTROL: begin
               read_data[CTRL_EN_BIT]  = enable_ff;
               read_data[CTRL_OPM_BIT] = one_pulse_ff;
               read_data[CTRL_DIR_BIT] = down_ff;
            end
            REG_PRESCALER: read_data = prescale_written_ff;
            REG_RELOAD:    read_data = reload_wide[DATA_WIDTH-1:0];
            REG_STATUS:    read_data[0] = pending_ff;
            REG_COUNT:     read_data = count_wide[DATA_WIDTH-1:0];
            default:       read_data = '0;
         endcase
      end
   end

   assign result.read_data   = read_data;
   assign result.update_flag = pending_in;
   assign result.running     = enable_in;

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff           <= 1'b0;
         one_pulse_ff        <= 1'b0;
         down_ff             <= 1'b0;
         prescale_written_ff <= '0;
         prescale_active_ff  <= '0;
         prescale_count_ff   <= '0;
         reload_ff           <= '1;
         count_ff            <= '0;
         pending_ff          <= 1'b0;
      end else if (step) begin
         enable_ff           <= enable_in;
         one_pulse_ff        <= one_pulse_in;
         down_ff             <= down_in;
         prescale_written_ff <= prescale_written_in;
         prescale_active_ff  <= prescale_active_in;
         prescale_count_ff   <= prescale_count_in;
         reload_ff           <= reload_in;
         count_ff            <= count_in;
         pending_ff          <= pending_in;
      end
   end

endmodule

// ===== sv/prescaled_reload_timer_core.sv =====
// ----------------------------------------------------------------------------
// prescaled_reload_timer_core
// Input register, then result register. Throughput: one request per cycle
// while rsp_stall does not hold a valid response, set by the single-pass
// state update in tmr_core. Synchronous active-high reset clears the
// pipeline and loads the timer reset state (reload all ones).
// ----------------------------------------------------------------------------
module prescaled_reload_timer_core
   import tmr_pkg::*;
#(
   parameter int COUNTER_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_mode,
   input  logic [2:0]            req_reg_index,
   input  logic [DATA_WIDTH-1:0] req_write_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [DATA_WIDTH-1:0] rsp_read_data,
   output logic                  rsp_update_flag,
   output logic                  rsp_running
);

   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_item_ff;
   rsp_type core_result;
   logic    advance;
   logic    accept;
   logic    step;

   // Pipeline control
   assign advance      = !out_valid_ff || !rsp_stall;
   assign req_stall    = in_valid_ff && !advance;
   assign accept       = req_valid && !req_stall;
   assign step         = in_valid_ff && advance;
   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input request register
   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff.mode       <= req_mode;
         in_item_ff.reg_index  <= req_reg_index;
         in_item_ff.write_data <= req_write_data;
      end
   end

   tmr_core #(
      .COUNTER_WIDTH(COUNTER_WIDTH)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .item  (in_item_ff),
      .result(core_result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (step) begin
         out_item_ff <= core_result;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_read_data   = out_item_ff.read_data;
   assign rsp_update_flag = out_item_ff.update_flag;
   assign rsp_running     = out_item_ff.running;

endmodule
